// ===== hw/rtl/rubp_pkg.sv =====
`timescale 1ns / 1ps

package rubp_pkg;

	localparam int unsigned MaxQuotient = 472;
	localparam int unsigned SegW        = 48;

	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_RICE = 2'd1,
		MODE_UTF8 = 2'd2,
		MODE_PAD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_FLUSH
	} state_t;

	// request to the chunk unit: pending byte plus the next run of source bits
	typedef struct packed {
		logic [6:0] pend;
		logic [2:0] pcount;
		logic [3:0] avail;
		logic [7:0] seg_top;
		logic       zero_phase;
	} step_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] take;
		logic       full;
		logic [6:0] pend;
		logic [2:0] pcount;
	} step_out_t;

endpackage

// ===== hw/rtl/rubp_in_if.sv =====
`timescale 1ns / 1ps

interface rubp_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  mode;
	logic        [31:0] raw_value;
	logic        [5:0]  bit_count;
	logic signed [31:0] sample;
	logic        [4:0]  rice_k;
	logic        [30:0] code_number;

	modport source (
		output valid, mode, raw_value, bit_count, sample, rice_k, code_number,
		input  ready
	);
	modport sink (
		input  valid, mode, raw_value, bit_count, sample, rice_k, code_number,
		output ready
	);
endinterface

// ===== hw/rtl/rubp_out_if.sv =====
`timescale 1ns / 1ps

interface rubp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       overflow;
	logic       last;

	modport source (
		output valid, out_byte, overflow, last,
		input  ready
	);
	modport sink (
		input  valid, out_byte, overflow, last,
		output ready
	);
endinterface

// ===== hw/rtl/rubp_chunk_unit.sv =====
`timescale 1ns / 1ps

// Shared packing step: moves up to eight source bits into the partial byte.
module rubp_chunk_unit (
	input  rubp_pkg::step_in_t  req,
	output rubp_pkg::step_out_t rsp
);

	logic [3:0] room;
	logic [3:0] take;
	logic [7:0] chunk;
	logic [7:0] merged;
	logic [3:0] total;

	always_comb begin
		room   = 4'd8 - {1'b0, req.pcount};
		take   = (req.avail < room) ? req.avail : room;
		// take of zero shifts everything out
		chunk  = req.zero_phase ? 8'd0 : (req.seg_top >> (4'd8 - take));
		merged = ({1'b0, req.pend} << take) | chunk;
		total  = {1'b0, req.pcount} + take;

		rsp.data_byte = merged;
		rsp.take      = take;
		rsp.full      = total[3];
		rsp.pend      = total[3] ? 7'd0 : merged[6:0];
		rsp.pcount    = total[3] ? 3'd0 : total[2:0];
	end

endmodule

// ===== hw/rtl/rice_utf8_bitstream_packer.sv =====
`timescale 1ns / 1ps

// An item is captured on acceptance and decoded in the prep state. Raw, rice and UTF-8 bits
// are then packed in the run state through chunk unit passes, each full byte entering the
// output register. A new item is accepted only in the idle state, once the last is done.
// A run of n bits over p pending bits takes ceil((p+n)/8) passes, rice unary zeros being a
// run of their own. A pass that fills a byte stalls while the output register is full.
// Reset (arst_n low) clears the partial byte, the sequencer and the output valid flag.
module rice_utf8_bitstream_packer #(
	parameter int unsigned MAX_QUOTIENT = rubp_pkg::MaxQuotient
) (
	input  logic            clk,
	input  logic            arst_n,
	rubp_in_if.sink         in_item,
	rubp_out_if.source      out_item
);

	localparam int unsigned ZcW  = $clog2(MAX_QUOTIENT + 1);
	localparam int unsigned RemW = $clog2(MAX_QUOTIENT + 49);
	localparam int unsigned SegW = rubp_pkg::SegW;

	rubp_pkg::state_t state_q, state_d;

	// captured item
	logic [1:0]  mode_q;
	logic [31:0] raw_q;
	logic [5:0]  cnt_q;
	logic [31:0] sample_q;
	logic [4:0]  k_q;
	logic [30:0] code_q;

	// bit source
	logic [ZcW-1:0]  zc_q;
	logic [SegW-1:0] seg_q;
	logic [5:0]      len_q;

	// partial byte
	logic [6:0] pend_q;
	logic [2:0] pcount_q;

	logic [7:0] flush_byte_q;
	logic       flush_ovf_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_ovf_q;
	logic       out_last_q;

	logic accept;
	logic out_free;

	// decode
	logic [31:0]     zz;
	logic [31:0]     quot;
	logic            quot_ovf;
	logic [31:0]     rem_left;
	logic [5:0]      raw_n;
	logic [SegW-1:0] seg_load;
	logic [5:0]      len_load;
	logic [ZcW-1:0]  zc_load;
	logic [30:0]     cv;
	logic [7:0]      pad_byte;

	// run step
	rubp_pkg::step_in_t  step_req;
	rubp_pkg::step_out_t step_rsp;
	logic [RemW-1:0] zc_w;
	logic [RemW-1:0] zc_after;
	logic [5:0]      len_after;
	logic [RemW-1:0] rem_after;
	logic            run_done;
	logic            run_halt;

	// sequencer controls
	logic do_run;
	logic do_flush;

	assign accept   = in_item.valid && in_item.ready;
	assign out_free = !out_valid_q || out_item.ready;

	// item decode, used in the prep cycle
	always_comb begin
		zz       = {sample_q[30:0], 1'b0} ^ {32{sample_q[31]}};
		quot     = zz >> k_q;
		quot_ovf = quot > 32'(MAX_QUOTIENT);
		rem_left = (k_q == 5'd0) ? 32'd0 : (zz << (6'd32 - {1'b0, k_q}));
		raw_n    = (cnt_q > 6'd32) ? 6'd32 : cnt_q;
		cv       = code_q;
		zc_load  = '0;
		seg_load = '0;
		len_load = '0;
		pad_byte = 8'({1'b0, pend_q} << (4'd8 - {1'b0, pcount_q}));

		case (rubp_pkg::mode_t'(mode_q))
			rubp_pkg::MODE_RAW: begin
				seg_load = {(raw_q << (6'd32 - raw_n)), 16'd0};
				len_load = raw_n;
			end
			rubp_pkg::MODE_RICE: begin
				zc_load  = ZcW'(quot);
				seg_load = {1'b1, rem_left, 15'd0};
				len_load = {1'b0, k_q} + 6'd1;
			end
			rubp_pkg::MODE_UTF8: begin
				if (cv < 31'h80) begin
					seg_load = {1'b0, cv[6:0], 40'd0};
					len_load = 6'd8;
				end else if (cv < 31'h800) begin
					seg_load = {3'b110, cv[10:6], 2'b10, cv[5:0], 32'd0};
					len_load = 6'd16;
				end else if (cv < 31'h10000) begin
					seg_load = {4'b1110, cv[15:12], 2'b10, cv[11:6], 2'b10, cv[5:0], 24'd0};
					len_load = 6'd24;
				end else if (cv < 31'h200000) begin
					seg_load = {5'b11110, cv[20:18], 2'b10, cv[17:12], 2'b10, cv[11:6],
						2'b10, cv[5:0], 16'd0};
					len_load = 6'd32;
				end else if (cv < 31'h4000000) begin
					seg_load = {6'b111110, cv[25:24], 2'b10, cv[23:18], 2'b10, cv[17:12],
						2'b10, cv[11:6], 2'b10, cv[5:0], 8'd0};
					len_load = 6'd40;
				end else begin
					seg_load = {7'b1111110, cv[30], 2'b10, cv[29:24], 2'b10, cv[23:18],
						2'b10, cv[17:12], 2'b10, cv[11:6], 2'b10, cv[5:0]};
					len_load = 6'd48;
				end
			end
			default: begin
			end
		endcase
	end

	// one pass of the chunk unit: unary zeros first, then the left-aligned segment
	always_comb begin
		zc_w                = RemW'(zc_q);
		step_req.pend       = pend_q;
		step_req.pcount     = pcount_q;
		step_req.zero_phase = (zc_q != '0);
		step_req.seg_top    = seg_q[SegW-1 -: 8];
		if (zc_q != '0)
			step_req.avail = (zc_w >= RemW'(8)) ? 4'd8 : zc_w[3:0];
		else
			step_req.avail = (len_q >= 6'd8) ? 4'd8 : len_q[3:0];
	end

	rubp_chunk_unit u_chunk (
		.req (step_req),
		.rsp (step_rsp)
	);

	always_comb begin
		zc_after  = step_req.zero_phase ? (zc_w - RemW'(step_rsp.take)) : zc_w;
		len_after = step_req.zero_phase ? len_q : (len_q - 6'(step_rsp.take));
		rem_after = zc_after + RemW'(len_after);
		run_done  = (zc_q == '0) && (len_q == 6'd0);
		run_halt  = step_rsp.full && !out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rubp_pkg::ST_IDLE:
				if (accept)
					state_d = rubp_pkg::ST_PREP;
			rubp_pkg::ST_PREP: begin
				if (rubp_pkg::mode_t'(mode_q) == rubp_pkg::MODE_PAD)
					state_d = (pcount_q != 3'd0) ? rubp_pkg::ST_FLUSH : rubp_pkg::ST_IDLE;
				else if (rubp_pkg::mode_t'(mode_q) == rubp_pkg::MODE_RICE && quot_ovf)
					state_d = rubp_pkg::ST_FLUSH;
				else
					state_d = rubp_pkg::ST_RUN;
			end
			rubp_pkg::ST_RUN:
				if (run_done)
					state_d = rubp_pkg::ST_IDLE;
			rubp_pkg::ST_FLUSH:
				if (out_free)
					state_d = rubp_pkg::ST_IDLE;
			default:
				state_d = rubp_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_item.ready = 1'b0;
		do_run        = 1'b0;
		do_flush      = 1'b0;
		case (state_q)
			rubp_pkg::ST_IDLE:  in_item.ready = 1'b1;
			rubp_pkg::ST_RUN:   do_run        = !run_done && !run_halt;
			rubp_pkg::ST_FLUSH: do_flush      = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rubp_pkg::ST_IDLE;
			zc_q     <= '0;
			len_q    <= '0;
			pend_q   <= '0;
			pcount_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rubp_pkg::ST_PREP) begin
				zc_q  <= zc_load;
				len_q <= len_load;
			end
			if (do_run) begin
				zc_q     <= ZcW'(zc_after);
				len_q    <= len_after;
				pend_q   <= step_rsp.pend;
				pcount_q <= step_rsp.pcount;
			end
			if (do_flush && !flush_ovf_q) begin
				pend_q   <= '0;
				pcount_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_item.mode;
			raw_q    <= in_item.raw_value;
			cnt_q    <= in_item.bit_count;
			sample_q <= in_item.sample;
			k_q      <= in_item.rice_k;
			code_q   <= in_item.code_number;
		end
		if (state_q == rubp_pkg::ST_PREP) begin
			seg_q        <= seg_load;
			flush_ovf_q  <= (rubp_pkg::mode_t'(mode_q) != rubp_pkg::MODE_PAD);
			flush_byte_q <= (rubp_pkg::mode_t'(mode_q) == rubp_pkg::MODE_PAD) ? pad_byte : 8'd0;
		end
		if (do_run && !step_req.zero_phase)
			seg_q <= seg_q << step_rsp.take;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_item.valid && out_item.ready)
				out_valid_q <= 1'b0;
			if ((do_run && step_rsp.full) || do_flush)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_run && step_rsp.full) begin
			out_byte_q <= step_rsp.data_byte;
			out_ovf_q  <= 1'b0;
			// no further byte once fewer than eight bits remain
			out_last_q <= (rem_after < RemW'(8));
		end else if (do_flush) begin
			out_byte_q <= flush_byte_q;
			out_ovf_q  <= flush_ovf_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_item.valid    = out_valid_q;
	assign out_item.out_byte = out_byte_q;
	assign out_item.overflow = out_ovf_q;
	assign out_item.last     = out_last_q;

endmodule

// ===== hw/rtl/rubp_checker.sv =====
`timescale 1ns / 1ps

module rubp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       overflow,
	input logic       last
);

	// a result held back by the sink stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
			&& $stable(overflow))
		else $error("result changed while stalled");

	// a rejected rice item is a single, empty result
	a_ovf_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last && (out_byte == 8'd0))
		else $error("overflow result malformed");

	// the block works on one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

endmodule

bind rice_utf8_bitstream_packer rubp_checker u_rubp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_item.valid),
	.in_ready  (in_item.ready),
	.out_valid (out_item.valid),
	.out_ready (out_item.ready),
	.out_byte  (out_item.out_byte),
	.overflow  (out_item.overflow),
	.last      (out_item.last)
);
